// ===== rtl/bgc_pkg.sv =====
// bgc_pkg: shared types and constants for the button gesture classifier.
// Event codes per key, result codes on the output and register indexes.
// No dependencies.
package bgc_pkg;

  localparam int unsigned CFG_W = 16;

  typedef enum logic [1:0] {
    CFG_SHORT_MIN = 2'd0,
    CFG_LONG_MIN  = 2'd1,
    CFG_GAP_MAX   = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } ev_t;

  typedef enum logic [2:0] {
    CODE_NONE      = 3'd0,
    CODE_K0_CLICK  = 3'd1,
    CODE_K0_DOUBLE = 3'd2,
    CODE_K0_LONG   = 3'd3,
    CODE_K1_CLICK  = 3'd4,
    CODE_K1_DOUBLE = 3'd5,
    CODE_K1_LONG   = 3'd6,
    CODE_RSVD      = 3'd7
  } code_t;

  // Result code for a pending event of key 0 or key 1.
  function automatic code_t event_code(logic key1, ev_t ev);
    code_t c;
    c = CODE_NONE;
    case (ev)
      EV_CLICK:  c = key1 ? CODE_K1_CLICK  : CODE_K0_CLICK;
      EV_DOUBLE: c = key1 ? CODE_K1_DOUBLE : CODE_K0_DOUBLE;
      EV_LONG:   c = key1 ? CODE_K1_LONG   : CODE_K0_LONG;
      default:   c = CODE_NONE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/button_gesture_classifier_unit.sv =====
// Path: an accepted poll beat goes through the input register, then through the per-key update
// into the result register. Throughput: one poll per cycle while the result beat is not stalled;
// the per-key state loop closes in the single update stage.
// Reset (rst_n low, synchronous): no beats held, thresholds back to 20/1000/300,
// all per-key state cleared. Depends on bgc_pkg.
module button_gesture_classifier_unit #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [15:0]               in_now,
  input  logic                      in_key0_level,
  input  logic                      in_key1_level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_event_code,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [bgc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int unsigned CMP_W = (TIME_BITS > bgc_pkg::CFG_W) ? TIME_BITS : bgc_pkg::CFG_W;

  // thresholds
  logic [bgc_pkg::CFG_W-1:0] short_min_r, long_min_r, gap_max_r;

  // input stage
  logic                 s1_valid_r;
  logic [TIME_BITS-1:0] s1_t_r;
  logic [1:0]           s1_level_r;

  // result stage
  logic                 out_valid_r;
  bgc_pkg::code_t       out_code_r;

  // per-key state
  bgc_pkg::ev_t         pend_r     [2];
  logic                 fcs_r      [2];
  logic                 held_r     [2];
  logic [TIME_BITS-1:0] press_r    [2];
  logic [TIME_BITS-1:0] rel_r      [2];

  bgc_pkg::ev_t         pend_upd   [2];
  bgc_pkg::ev_t         pend_nxt   [2];
  logic                 fcs_nxt    [2];
  logic                 held_nxt   [2];
  logic [TIME_BITS-1:0] press_nxt  [2];
  logic [TIME_BITS-1:0] rel_nxt    [2];
  bgc_pkg::code_t       code_nxt;

  logic advance;
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

  for (genvar k = 0; k < 2; k++) begin : g_key
    logic [TIME_BITS-1:0] gap_e, hold_e;
    logic                 gap_over, is_click, fcs_mid;
    bgc_pkg::ev_t         pend_mid;

    assign gap_e  = s1_t_r - rel_r[k];
    assign hold_e = s1_t_r - press_r[k];
    assign gap_over = CMP_W'(gap_e) > CMP_W'(gap_max_r);
    assign is_click = (CMP_W'(hold_e) >= CMP_W'(short_min_r)) &&
                      (CMP_W'(hold_e) <  CMP_W'(long_min_r));

    always_comb begin
      // lone first click turns into a single click once the gap has passed
      fcs_mid  = fcs_r[k] && !gap_over;
      pend_mid = (fcs_r[k] && gap_over) ? bgc_pkg::EV_CLICK : pend_r[k];

      pend_upd[k]  = pend_mid;
      fcs_nxt[k]   = fcs_mid;
      held_nxt[k]  = held_r[k];
      press_nxt[k] = press_r[k];
      rel_nxt[k]   = rel_r[k];

      if (!s1_level_r[k]) begin
        if (!held_r[k]) begin
          held_nxt[k]  = 1'b1;
          press_nxt[k] = s1_t_r;
        end else if (CMP_W'(hold_e) >= CMP_W'(long_min_r)) begin
          pend_upd[k] = bgc_pkg::EV_LONG;
        end
      end else if (held_r[k]) begin
        if (is_click) begin
          if (!fcs_mid) begin
            rel_nxt[k] = s1_t_r;
            fcs_nxt[k] = 1'b1;
          end else begin
            if (!gap_over) begin
              pend_upd[k] = bgc_pkg::EV_DOUBLE;
            end
            fcs_nxt[k] = 1'b0;
          end
        end
        held_nxt[k] = 1'b0;
      end
    end
  end

  // at most one event per poll, key 0 first; only the reported one is cleared
  always_comb begin
    pend_nxt[0] = pend_upd[0];
    pend_nxt[1] = pend_upd[1];
    code_nxt    = bgc_pkg::CODE_NONE;
    if (pend_upd[0] != bgc_pkg::EV_NONE) begin
      code_nxt    = bgc_pkg::event_code(1'b0, pend_upd[0]);
      pend_nxt[0] = bgc_pkg::EV_NONE;
    end else if (pend_upd[1] != bgc_pkg::EV_NONE) begin
      code_nxt    = bgc_pkg::event_code(1'b1, pend_upd[1]);
      pend_nxt[1] = bgc_pkg::EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_min_r <= bgc_pkg::CFG_W'(20);
      long_min_r  <= bgc_pkg::CFG_W'(1000);
      gap_max_r   <= bgc_pkg::CFG_W'(300);
    end else if (cfg_we) begin
      case (bgc_pkg::cfg_idx_t'(cfg_index))
        bgc_pkg::CFG_SHORT_MIN: short_min_r <= cfg_wdata;
        bgc_pkg::CFG_LONG_MIN:  long_min_r  <= cfg_wdata;
        bgc_pkg::CFG_GAP_MAX:   gap_max_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_t_r     <= TIME_BITS'(in_now);
      s1_level_r <= {in_key1_level, in_key0_level};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_code_r <= code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        pend_r[i]  <= bgc_pkg::EV_NONE;
        fcs_r[i]   <= 1'b0;
        held_r[i]  <= 1'b0;
        press_r[i] <= '0;
        rel_r[i]   <= '0;
      end
    end else if (advance && s1_valid_r) begin
      for (int i = 0; i < 2; i++) begin
        pend_r[i]  <= pend_nxt[i];
        fcs_r[i]   <= fcs_nxt[i];
        held_r[i]  <= held_nxt[i];
        press_r[i] <= press_nxt[i];
        rel_r[i]   <= rel_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/bgc_checker.sv =====
// bgc_checker: port-level assertions for button_gesture_classifier_unit,
// attached by the bind statement at the end. Depends on bgc_pkg.
module bgc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_event_code
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat visible after reset");

  // no reserved code ever leaves the block
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code != bgc_pkg::CODE_RSVD)
    else $error("reserved event code");

  // an accepted poll beat passes the input register and reaches the result register when the output is not stalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("result beat missing after accepted poll");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code))
    else $error("stalled result beat changed");

endmodule

bind button_gesture_classifier_unit bgc_checker u_bgc_checker (.*);

// ===== test/tb_button_gesture_classifier_unit.sv =====
// Self-checking testbench for button_gesture_classifier_unit: drives poll beats from a queue,
// predicts each event code in-bench and compares it with every result beat.
// Depends on bgc_pkg and the button_gesture_classifier_unit RTL.
module tb_button_gesture_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int N_PHASES    = 8;

  typedef struct {
    logic [15:0] stamp;
    logic        lvl0;
    logic        lvl1;
  } poll_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [15:0]               in_now = '0;
  logic                      in_key0_level = 1'b1;
  logic                      in_key1_level = 1'b1;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [2:0]                out_event_code;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_index = '0;
  logic [bgc_pkg::CFG_W-1:0] cfg_wdata = '0;

  // Threshold copy and per-key gesture state of the predictor
  logic [15:0]  click_min, long_min, gap_max;
  bgc_pkg::ev_t key_pend[2];
  logic         key_armed[2];
  logic         key_down[2];
  logic [15:0]  down_at[2];
  logic [15:0]  up_at[2];

  poll_t          poll_q[$];
  bgc_pkg::code_t code_q[$];

  int n_queued = 0;
  int n_checked = 0;
  int n_accepted = 0;
  int err_count = 0;
  int idle_cycles = 0;
  int code_hits[8];
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  // Random gesture generator state
  logic [15:0] gen_stamp = '0;
  logic        gen_lvl[2] = '{1'b1, 1'b1};
  int          gen_run[2] = '{0, 0};

  // click, long, gap, time step scale
  int unsigned phase_cfg[N_PHASES][4] = '{
    '{20, 1000, 300, 250},
    '{3, 20, 15, 5},
    '{0, 65535, 65535, 20000},
    '{65535, 0, 0, 40},
    '{5, 40, 0, 10},
    '{0, 0, 0, 0},
    '{1, 2, 3, 1},
    '{10, 100, 50, 25}
  };

  button_gesture_classifier_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_now        (in_now),
    .in_key0_level (in_key0_level),
    .in_key1_level (in_key1_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_code(out_event_code),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic void step_key(int k, logic [15:0] t, logic pressed);
    logic [15:0] held_for;
    logic [15:0] since_up;
    held_for = t - down_at[k];
    since_up = t - up_at[k];
    // a lone click turns into a single click once the gap has run out
    if (key_armed[k] && since_up > gap_max) begin
      key_armed[k] = 1'b0;
      key_pend[k] = bgc_pkg::EV_CLICK;
    end
    if (pressed) begin
      if (!key_down[k]) begin
        key_down[k] = 1'b1;
        down_at[k] = t;
      end else if (held_for >= long_min) begin
        key_pend[k] = bgc_pkg::EV_LONG;
      end
    end else if (key_down[k]) begin
      if (held_for >= click_min && held_for < long_min) begin
        if (!key_armed[k]) begin
          up_at[k] = t;
          key_armed[k] = 1'b1;
        end else begin
          if (since_up <= gap_max) key_pend[k] = bgc_pkg::EV_DOUBLE;
          key_armed[k] = 1'b0;
        end
      end
      key_down[k] = 1'b0;
    end
  endfunction

  function automatic bgc_pkg::code_t classify_poll(logic [15:0] t, logic lvl0, logic lvl1);
    bgc_pkg::code_t c;
    c = bgc_pkg::CODE_NONE;
    step_key(0, t, !lvl0);
    step_key(1, t, !lvl1);
    // key 0 wins; the other key's event waits for a later poll
    for (int k = 0; k < 2; k++) begin
      if (c == bgc_pkg::CODE_NONE && key_pend[k] != bgc_pkg::EV_NONE) begin
        c = bgc_pkg::code_t'(3 * k + int'(key_pend[k]));
        key_pend[k] = bgc_pkg::EV_NONE;
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 30) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic push_poll(logic [15:0] t, logic l0, logic l1);
    poll_t p;
    p.stamp = t;
    p.lvl0 = l0;
    p.lvl1 = l1;
    poll_q.push_back(p);
    n_queued++;
  endtask

  task automatic write_reg(bgc_pkg::cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bgc_pkg::CFG_SHORT_MIN: click_min = val;
      bgc_pkg::CFG_LONG_MIN:  long_min = val;
      bgc_pkg::CFG_GAP_MAX:   gap_max = val;
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (n_checked != n_queued);
  endtask

  // Mostly well-formed press/release runs with an advancing time stamp, some noise beats
  task automatic gen_polls(int n, int unsigned scale);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_poll(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 7) == 0) gen_stamp += 16'($urandom_range(0, 8 * scale));
        else gen_stamp += 16'($urandom_range(0, scale));
        for (int k = 0; k < 2; k++) begin
          if (gen_run[k] == 0) begin
            gen_lvl[k] = ~gen_lvl[k];
            gen_run[k] = $urandom_range(1, 6);
          end
          gen_run[k]--;
        end
        push_poll(gen_stamp, gen_lvl[0], gen_lvl[1]);
      end
    end
  endtask

  always @(posedge clk) begin : drive_polls
    poll_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        code_q.push_back(classify_poll(in_now, in_key0_level, in_key1_level));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (poll_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          p = poll_q.pop_front();
          in_valid <= 1'b1;
          in_now <= p.stamp;
          in_key0_level <= p.lvl0;
          in_key1_level <= p.lvl1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_events
    bgc_pkg::code_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (code_q.size() == 0) begin
        report_mismatch($sformatf("event beat %0d with nothing expected", out_event_code));
      end else begin
        want = code_q.pop_front();
        if (out_event_code !== want)
          report_mismatch($sformatf("event_code got %0d want %0d (%s)",
                                    out_event_code, want, want.name()));
      end
      code_hits[out_event_code]++;
      n_checked++;
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < rx_stall_pct);
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    click_min = 16'd20;
    long_min = 16'd1000;
    gap_max = 16'd300;
    for (int k = 0; k < 2; k++) begin
      key_pend[k] = bgc_pkg::EV_NONE;
      key_armed[k] = 1'b0;
      key_down[k] = 1'b0;
      down_at[k] = '0;
      up_at[k] = '0;
    end
    for (int i = 0; i < 8; i++) code_hits[i] = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // unused index must leave the defaults alone
    write_reg(bgc_pkg::CFG_UNUSED, 16'hFFFF);

    // too short, then a double click on key 0
    push_poll(0, 0, 1);
    push_poll(15, 1, 1);
    push_poll(100, 0, 1);
    push_poll(150, 1, 1);
    push_poll(200, 0, 1);
    push_poll(250, 1, 1);
    // long press repeats while held, its release is too long for a click
    push_poll(300, 0, 1);
    push_poll(2000, 0, 1);
    push_poll(2001, 0, 1);
    push_poll(2002, 1, 1);
    // key 0 long and key 1 double land on the same poll
    push_poll(4000, 0, 1);
    push_poll(4800, 0, 0);
    push_poll(4850, 0, 1);
    push_poll(4900, 0, 0);
    push_poll(5000, 0, 1);
    push_poll(5001, 1, 1);
    // click across the timestamp wrap, then overwritten by a long press
    push_poll(65500, 0, 1);
    push_poll(65535, 1, 1);
    push_poll(20, 0, 1);
    push_poll(1100, 0, 1);
    push_poll(1101, 1, 1);
    // key 1 long, then single clicks on both keys expiring together
    push_poll(1200, 1, 0);
    push_poll(2300, 1, 0);
    push_poll(2301, 0, 1);
    push_poll(2350, 1, 0);
    push_poll(2400, 1, 1);
    push_poll(2800, 1, 1);
    push_poll(2801, 1, 1);
    wait_quiet();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 5) begin
        phase_cfg[5][0] = $urandom_range(0, 40);
        phase_cfg[5][1] = phase_cfg[5][0] + $urandom_range(1, 300);
        phase_cfg[5][2] = $urandom_range(0, 300);
        phase_cfg[5][3] = phase_cfg[5][1] / 4 + 1;
      end
      write_reg(bgc_pkg::CFG_SHORT_MIN, 16'(phase_cfg[ph][0]));
      write_reg(bgc_pkg::CFG_LONG_MIN, 16'(phase_cfg[ph][1]));
      write_reg(bgc_pkg::CFG_GAP_MAX, 16'(phase_cfg[ph][2]));
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
        default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
      endcase
      if (ph == 2) begin
        // sender holds off mid-phase until the pipe has drained
        gen_polls(50, phase_cfg[ph][3]);
        wait_quiet();
        gen_polls(50, phase_cfg[ph][3]);
      end else begin
        gen_polls(100, phase_cfg[ph][3]);
      end
      wait_quiet();
    end

    repeat (8) @(posedge clk);
    if (code_q.size() != 0)
      report_mismatch($sformatf("%0d event beats never arrived", code_q.size()));

    $display("Covered %0d polls over %0d threshold settings plus directed gestures;",
             n_accepted, N_PHASES + 1);
    $display("codes seen k0 click/double/long %0d/%0d/%0d, k1 %0d/%0d/%0d, none %0d",
             code_hits[1], code_hits[2], code_hits[3],
             code_hits[4], code_hits[5], code_hits[6], code_hits[0]);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
